// ===== sv/report_deframer_rx_top_macros.svh =====
// Assertion macros shared by the report deframer modules.
`ifndef REPORT_DEFRAMER_RX_TOP_MACROS_SVH
`define REPORT_DEFRAMER_RX_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDRX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RDRX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rdrx_pkg.sv =====
// Types and constants of the report deframer receive path.
`timescale 1ns / 1ps
package rdrx_pkg;

  // Transaction kinds on the input channel.
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_CONSUME = 2'd2;

  // Configuration register indexes.
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_SYNC    = 1'b1;

  // Configuration reset values.
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] SYNC_RESET    = 16'hABBA;

  // Header byte positions within a report.
  localparam int HDR_SYNC_HI = 0;
  localparam int HDR_SYNC_LO = 1;
  localparam int HDR_LEN_HI  = 2;
  localparam int HDR_LEN_LO  = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RECV = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_IGN  = 2'd0,
    ROLE_HDR  = 2'd1,
    ROLE_CONT = 2'd2
  } role_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       report_start;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        packet_last;
    logic [15:0] packet_length;
  } result_t;

endpackage

// ===== sv/rdrx_in_if.sv =====
// Input channel: report bytes, time ticks and consume events.
`timescale 1ns / 1ps
interface rdrx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       report_start;

  modport source (output valid, kind, data_byte, report_start, input ready);
  modport sink (input valid, kind, data_byte, report_start, output ready);
endinterface

// ===== sv/rdrx_out_if.sv =====
// Output channel: reassembled payload bytes.
`timescale 1ns / 1ps
interface rdrx_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic        packet_last;
  logic [15:0] packet_length;

  modport source (output valid, payload_byte, byte_valid, packet_last, packet_length,
                  input ready);
  modport sink (input valid, payload_byte, byte_valid, packet_last, packet_length,
                output ready);
endinterface

// ===== sv/report_deframer_rx_top.sv =====
// Top level of the report deframer receive path.
//
//   Channel   Direction  Carries
//   item      in         kind, data_byte, report_start (valid/ready)
//   result    out        payload_byte, byte_valid, packet_last, packet_length
//   wr_*      in         configuration writes, no read-back
//
// One transaction per cycle is accepted while no held result stalls the flow; a result
// reaches the output through the input register and then the result register.
// Reset clears all reassembly state and loads the configuration defaults.
// A held result stalls only when the next transaction also makes a result.
`timescale 1ns / 1ps
module report_deframer_rx_top
  import rdrx_pkg::*;
#(
  parameter int REPORT_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  rdrx_in_if.sink     item,
  rdrx_out_if.source  result
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Gather the input fields.
  assign in_item = '{kind: item.kind, data_byte: item.data_byte,
                     report_start: item.report_start};

  rdrx_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (held_valid),
    .item       (held_item)
  );

  rdrx_core #(
    .REPORT_BYTES (REPORT_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .item_valid (held_valid),
    .item       (held_item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  rdrx_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_res   (out_res)
  );

  // Spread the result onto the output channel.
  assign result.payload_byte  = out_res.payload_byte;
  assign result.byte_valid    = out_res.byte_valid;
  assign result.packet_last   = out_res.packet_last;
  assign result.packet_length = out_res.packet_length;

endmodule

// ===== sv/rdrx_in_stage.sv =====
// Input register stage of the report deframer.
`timescale 1ns / 1ps
module rdrx_in_stage
  import rdrx_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  // The stage refills whenever it is empty or its item moves on.
  assign in_ready = !item_valid || take;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== sv/rdrx_core.sv =====
// Reassembly state and per-transaction decode of the report deframer.
`timescale 1ns / 1ps
module rdrx_core
  import rdrx_pkg::*;
#(
  parameter int REPORT_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  input  logic        item_valid,
  input  item_t       item,
  input  logic        out_free,
  output logic        take,
  output logic        res_valid,
  output result_t     res
);
  `include "report_deframer_rx_top_macros.svh"

  localparam int PW = $clog2(REPORT_BYTES + 1);

  logic [15:0]   timeout_ticks;
  logic [15:0]   sync_word;
  phase_t        phase, phase_next;
  role_t         role, role_next;
  logic [PW-1:0] position, position_next;
  logic          first_sync_ok, first_sync_ok_next;
  logic [15:0]   declared_length, declared_length_next;
  logic [16:0]   received_count, received_count_next;
  logic [15:0]   idle_ticks, idle_ticks_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      sync_word     <= SYNC_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_TIMEOUT: timeout_ticks <= wr_data;
        REG_SYNC:    sync_word     <= wr_data;
        default:     timeout_ticks <= timeout_ticks;
      endcase
    end
  end

  // The item moves on unless it makes a result that the output cannot hold.
  assign take = item_valid && (!res_valid || out_free);

  // Next state and result for the item held in the input register.
  always_comb begin
    logic [PW-1:0] pos;
    logic [16:0]   cnt;
    phase_next           = phase;
    role_next            = role;
    position_next        = position;
    first_sync_ok_next   = first_sync_ok;
    declared_length_next = declared_length;
    received_count_next  = received_count;
    idle_ticks_next      = idle_ticks;
    res_valid            = 1'b0;
    res                  = '0;
    pos                  = position;
    cnt                  = received_count + 17'd1;

    case (item.kind)
      KIND_BYTE: begin
        // A report start checks the gap, clears the tick count and picks a role.
        if (item.report_start) begin
          if (idle_ticks > timeout_ticks) begin
            phase_next = PH_IDLE;
          end
          idle_ticks_next = '0;
          pos             = '0;
          case (phase_next)
            PH_IDLE: role_next = ROLE_HDR;
            PH_RECV: role_next = ROLE_CONT;
            default: role_next = ROLE_IGN;
          endcase
        end
        position_next = pos;
        if (pos < PW'(REPORT_BYTES)) begin
          position_next = pos + PW'(1);
          if (role_next == ROLE_HDR && pos == PW'(HDR_SYNC_HI)) begin
            first_sync_ok_next = (item.data_byte == sync_word[15:8]);
            if (item.data_byte != sync_word[15:8]) begin
              role_next = ROLE_IGN;
            end
          end else if (role_next == ROLE_HDR && pos == PW'(HDR_SYNC_LO)) begin
            if (!first_sync_ok || item.data_byte != sync_word[7:0]) begin
              role_next = ROLE_IGN;
            end
          end else if (role_next == ROLE_HDR && pos == PW'(HDR_LEN_HI)) begin
            declared_length_next = {item.data_byte, declared_length[7:0]};
          end else if (role_next == ROLE_HDR && pos == PW'(HDR_LEN_LO)) begin
            declared_length_next = {declared_length[15:8], item.data_byte};
            received_count_next  = '0;
            if (declared_length_next == 16'd0) begin
              // Empty packet completes on its header.
              phase_next        = PH_DONE;
              role_next         = ROLE_IGN;
              res_valid         = 1'b1;
              res.packet_last   = 1'b1;
              res.packet_length = declared_length_next;
            end else begin
              phase_next = PH_RECV;
            end
          end else if ((role_next == ROLE_HDR || role_next == ROLE_CONT)
                       && phase_next == PH_RECV) begin
            // Payload byte; the one that reaches the length closes the packet.
            received_count_next = cnt;
            if (cnt >= {1'b0, declared_length}) begin
              phase_next      = PH_DONE;
              role_next       = ROLE_IGN;
              res.packet_last = 1'b1;
            end
            res_valid         = 1'b1;
            res.payload_byte  = item.data_byte;
            res.byte_valid    = 1'b1;
            res.packet_length = declared_length;
          end
        end
      end
      KIND_TICK: begin
        if (idle_ticks != 16'hFFFF) begin
          idle_ticks_next = idle_ticks + 16'd1;
        end
      end
      KIND_CONSUME: begin
        if (phase == PH_DONE) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    if (!item_valid) begin
      res_valid = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      role            <= ROLE_IGN;
      position        <= '0;
      first_sync_ok   <= 1'b0;
      declared_length <= '0;
      received_count  <= '0;
      idle_ticks      <= '0;
    end else if (take) begin
      phase           <= phase_next;
      role            <= role_next;
      position        <= position_next;
      first_sync_ok   <= first_sync_ok_next;
      declared_length <= declared_length_next;
      received_count  <= received_count_next;
      idle_ticks      <= idle_ticks_next;
    end
  end

  // While receiving, the count stays below the declared length.
  `RDRX_ASSERT_NOW(a_count_below_length, phase == PH_RECV, received_count < {1'b0, declared_length}, "received count reached length while receiving")
  // The report position never runs past the report size.
  `RDRX_ASSERT_NOW(a_position_bound, 1'b1, position <= PW'(REPORT_BYTES), "report position past report size")
  // Any closing result leaves the block complete.
  `RDRX_ASSERT_NEXT(a_last_completes, take && res_valid && res.packet_last, phase == PH_DONE, "packet end did not complete")

endmodule

// ===== sv/rdrx_out_reg.sv =====
// Result register of the report deframer.
`timescale 1ns / 1ps
module rdrx_out_reg
  import rdrx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);
  `include "report_deframer_rx_top_macros.svh"

  // Room for a new result when empty or when the held one leaves now.
  assign out_free = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (out_free && load) begin
      out_res <= res;
    end
  end

  // An empty-packet result is always a closing result with a zero byte.
  `RDRX_ASSERT_NOW(a_empty_form, out_valid && !out_res.byte_valid, out_res.packet_last && out_res.payload_byte == 8'd0, "malformed empty packet result")

endmodule
